// File: rtl/rmub_pkg.sv
// ----------------------------------------------------------------------------
// rmub_pkg
// Types, constants and the bound table of the rate-monotonic admission test.
// ----------------------------------------------------------------------------
package rmub_pkg;

	localparam int DATA_W  = 32;
	localparam int ACC_W   = 24;
	localparam int CNT_W   = 6;
	localparam int BOUND_W = 25;
	localparam int TBL_LEN = 33;

	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

	// n*(2^(1/n)-1) in units of 1e-4, indexed by task count
	localparam logic [13:0] BOUND_E4 [TBL_LEN] = '{
		14'd0,    14'd10000, 14'd8284, 14'd7798, 14'd7568, 14'd7435, 14'd7348,
		14'd7286, 14'd7241,  14'd7205, 14'd7177, 14'd7155, 14'd7136, 14'd7120,
		14'd7106, 14'd7094,  14'd7084, 14'd7075, 14'd7067, 14'd7059, 14'd7053,
		14'd7047, 14'd7042,  14'd7037, 14'd7033, 14'd7028, 14'd7025, 14'd7021,
		14'd7018, 14'd7015,  14'd7012, 14'd7010, 14'd7007
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_ACC
	} rmub_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_CHECK,
		DV_ITER
	} rmub_div_state_t;

	// bound entry rounded to nearest in the accumulator format
	function automatic logic [BOUND_W-1:0] bound_fixed(input int n, input int frac);
		longint unsigned num;
		num = (longint'(BOUND_E4[n]) << frac) + 64'd5000;
		return BOUND_W'(num / 64'd10000);
	endfunction

endpackage

// File: rtl/rmub_if.sv
// ----------------------------------------------------------------------------
// rmub_if
// Valid/ready channels for task records and admission verdicts.
// ----------------------------------------------------------------------------
interface rmub_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] task_compute;
	logic [31:0] task_period;
	logic        is_runnable;
	logic        is_last;

	modport source (output valid, task_compute, task_period, is_runnable, is_last,
		input ready);
	modport sink (input valid, task_compute, task_period, is_runnable, is_last,
		output ready);
endinterface

interface rmub_rsp_if;
	logic        valid;
	logic        ready;
	logic        schedulable;
	logic [23:0] utilization_sum;
	logic [5:0]  runnable_count;
	logic        period_error;

	modport source (output valid, schedulable, utilization_sum, runnable_count,
		period_error, input ready);
	modport sink (input valid, schedulable, utilization_sum, runnable_count,
		period_error, output ready);
endinterface

// File: rtl/rmub_div.sv
// ----------------------------------------------------------------------------
// rmub_div
// Radix-2 restoring divider: floor(dividend * 2^FRAC_BITS / divisor),
// saturating just below 16.0, one quotient bit per cycle on one subtractor.
// ----------------------------------------------------------------------------
module rmub_div
	import rmub_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_W-1:0]     dividend,
	input  logic [DATA_W-1:0]     divisor,
	output logic                  done,
	output logic [FRAC_BITS+3:0]  quo
);

	localparam int QW = FRAC_BITS + 4;
	localparam int CW = $clog2(QW + 1);

	rmub_div_state_t st_q, st_d;

	logic [DATA_W:0]   rem_q;
	logic [DATA_W-1:0] per_q;
	logic [QW-1:0]     shf_q;
	logic [QW-1:0]     quo_q;
	logic [CW-1:0]     cnt_q;
	logic              done_q;

	logic [DATA_W:0]   sub_a;
	logic [DATA_W+1:0] diff;
	logic              borrow;
	logic              fin;

	// shared subtractor
	assign sub_a  = (st_q == DV_ITER) ? {rem_q[DATA_W-1:0], shf_q[QW-1]} : rem_q;
	assign diff   = {1'b0, sub_a} - {2'b00, per_q};
	assign borrow = diff[DATA_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= DV_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		fin  = 1'b0;
		case (st_q)
			DV_IDLE: begin
				if (start) begin
					st_d = DV_CHECK;
				end
			end
			DV_CHECK: begin
				if (!borrow) begin
					st_d = DV_IDLE;
					fin  = 1'b1;
				end else begin
					st_d = DV_ITER;
				end
			end
			DV_ITER: begin
				if (cnt_q == CW'(1)) begin
					st_d = DV_IDLE;
					fin  = 1'b1;
				end
			end
			default: begin
				st_d = DV_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin;
			if (st_q == DV_CHECK) begin
				cnt_q <= CW'(QW);
			end else if (st_q == DV_ITER) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			DV_IDLE: begin
				if (start) begin
					rem_q <= {5'b0, dividend[DATA_W-1:4]};
					shf_q <= {dividend[3:0], {FRAC_BITS{1'b0}}};
					per_q <= divisor;
					quo_q <= '0;
				end
			end
			DV_CHECK: begin
				// integer part of 16 or more saturates
				if (!borrow) begin
					quo_q <= '1;
				end
			end
			DV_ITER: begin
				rem_q <= borrow ? sub_a : diff[DATA_W:0];
				quo_q <= {quo_q[QW-2:0], !borrow};
				shf_q <= {shf_q[QW-2:0], 1'b0};
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: rtl/rm_utilization_bound_test.sv
// ----------------------------------------------------------------------------
// rm_utilization_bound_test
// Rate-monotonic admission test: sums compute/period over runnable tasks and
// checks the sum against the utilization bound for the runnable count.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   task_compute, task_period, is_runnable, is_last
//   rsp      out  valid/ready   schedulable, utilization_sum, runnable_count,
//                               period_error
//
// A runnable task with a nonzero period waits in ST_DIV for the one-bit-per-cycle
// divider, which stops after its check step when the quotient clips at 16.0;
// other records go from idle straight to ST_ACC.
// req.ready is high only while idle; one record is in work at a time.
// A verdict waits in the output register; only a last record stalls on it.
// Reset clears the running sum, count and error mark.
// ----------------------------------------------------------------------------
module rm_utilization_bound_test
	import rmub_pkg::*;
#(
	parameter int MAX_TASKS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	rmub_req_if.sink  req,
	rmub_rsp_if.source rsp
);

	localparam int QW = FRAC_BITS + 4;
	localparam int SW = ((QW > ACC_W) ? QW : ACC_W) + 1;
	localparam logic [CNT_W-1:0] MAXT = CNT_W'(MAX_TASKS);

	rmub_state_t st_q, st_d;

	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             zps_q;
	logic             run_q;
	logic             last_q;
	logic             zp_q;
	logic             use_div_q;

	logic             o_vld_q;
	logic             o_sched_q;
	logic [ACC_W-1:0] o_sum_q;
	logic [CNT_W-1:0] o_cnt_q;
	logic             o_perr_q;

	logic             accept;
	logic             div_start;
	logic             div_done;
	logic [QW-1:0]    div_quo;
	logic             fire;

	logic [BOUND_W-1:0] bound_tbl [TBL_LEN];
	logic [SW-1:0]      sum;
	logic [ACC_W-1:0]   acc_n;
	logic [CNT_W-1:0]   cnt_n;
	logic               zps_n;
	logic               ok;

	for (genvar gi = 0; gi < TBL_LEN; gi++) begin : g_bound
		assign bound_tbl[gi] = bound_fixed(gi, FRAC_BITS);
	end

	rmub_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (req.task_compute),
		.divisor  (req.task_period),
		.done     (div_done),
		.quo      (div_quo)
	);

	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d      = st_q;
		req.ready = 1'b0;
		div_start = 1'b0;
		fire      = 1'b0;
		case (st_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.is_runnable && (req.task_period != '0)) begin
						div_start = 1'b1;
						st_d      = ST_DIV;
					end else begin
						st_d = ST_ACC;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					st_d = ST_ACC;
				end
			end
			ST_ACC: begin
				if (!(last_q && o_vld_q && !rsp.ready)) begin
					fire = 1'b1;
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	// accumulate, count and judge
	always_comb begin
		sum   = SW'(acc_q) + (use_div_q ? SW'(div_quo) : '0);
		acc_n = (sum > SW'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];
		cnt_n = (run_q && (cnt_q < MAXT)) ? cnt_q + CNT_W'(1) : cnt_q;
		zps_n = zps_q || zp_q;
		ok    = !zps_n && ({1'b0, acc_n} <= bound_tbl[cnt_n]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			cnt_q     <= '0;
			zps_q     <= 1'b0;
			run_q     <= 1'b0;
			last_q    <= 1'b0;
			zp_q      <= 1'b0;
			use_div_q <= 1'b0;
			o_vld_q   <= 1'b0;
		end else begin
			if (accept) begin
				run_q     <= req.is_runnable;
				last_q    <= req.is_last;
				zp_q      <= req.is_runnable && (req.task_period == '0);
				use_div_q <= req.is_runnable && (req.task_period != '0);
			end
			if (fire) begin
				if (last_q) begin
					acc_q <= '0;
					cnt_q <= '0;
					zps_q <= 1'b0;
				end else begin
					acc_q <= acc_n;
					cnt_q <= cnt_n;
					zps_q <= zps_n;
				end
			end
			o_vld_q <= (o_vld_q && !rsp.ready) || (fire && last_q);
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_q) begin
			o_sched_q <= ok;
			o_sum_q   <= acc_n;
			o_cnt_q   <= cnt_n;
			o_perr_q  <= zps_n;
		end
	end

	assign rsp.valid           = o_vld_q;
	assign rsp.schedulable     = o_sched_q;
	assign rsp.utilization_sum = o_sum_q;
	assign rsp.runnable_count  = o_cnt_q;
	assign rsp.period_error    = o_perr_q;

	// an error never comes with a schedulable verdict
	a_err_unsched: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.period_error && rsp.schedulable))
		else $error("period error reported as schedulable");

	// count never passes the task limit
	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.runnable_count <= MAXT))
		else $error("runnable count above limit");

	// one record in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("new transaction taken while busy");

	// divider only runs for runnable records with a nonzero period
	a_div_use: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (st_q == ST_DIV) && use_div_q)
		else $error("divider finished outside a division");

endmodule

// File: tb/rmub_admission_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rmub_admission_monitor
// Watches the task record and verdict channels of the admission test. Keeps
// its own running utilization sum, runnable count and zero-period mark,
// predicts the verdict for each last record, and compares every verdict
// transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rmub_admission_monitor
	import rmub_pkg::*;
#(
	parameter int MAX_TASKS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	rmub_req_if  req,
	rmub_rsp_if  rsp,
	output int   fail_count,
	output int   pending,
	output int   verdicts
);

	typedef struct packed {
		logic             schedulable;
		logic [ACC_W-1:0] utilization_sum;
		logic [CNT_W-1:0] runnable_count;
		logic             period_error;
	} verdict_t;

	logic [ACC_W-1:0] util_acc;
	logic [CNT_W-1:0] runnable_tally;
	logic             zero_period_flag;
	verdict_t         verdict_q[$];

	// table entry rounded to nearest in the accumulator format
	function automatic logic [63:0] bound_for_count(input logic [CNT_W-1:0] n);
		int idx;
		idx = (n < TBL_LEN) ? int'(n) : TBL_LEN - 1;
		return ((64'(BOUND_E4[idx]) << FRAC_BITS) + 64'd5000) / 64'd10000;
	endfunction

	// compute/period in fixed point, clipped just below 16.0
	function automatic logic [63:0] task_share(input logic [31:0] c, input logic [31:0] p);
		logic [63:0] q;
		logic [63:0] qmax;
		qmax = (64'd1 << (FRAC_BITS + 4)) - 64'd1;
		q = (64'(c) << FRAC_BITS) / 64'(p);
		return (q > qmax) ? qmax : q;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t    seen;
		verdict_t    want;
		logic [63:0] sum;
		if (!arst_n) begin
			util_acc = '0;
			runnable_tally = '0;
			zero_period_flag = 1'b0;
			verdict_q.delete();
			fail_count = 0;
			pending = 0;
			verdicts = 0;
		end else begin
			// verdict transaction first: it belongs to an earlier set
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				seen.schedulable = rsp.schedulable;
				seen.utilization_sum = rsp.utilization_sum;
				seen.runnable_count = rsp.runnable_count;
				seen.period_error = rsp.period_error;
				if (verdict_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected verdict sched=%0d sum=%h cnt=%0d err=%0d", $time,
						seen.schedulable, seen.utilization_sum, seen.runnable_count,
						seen.period_error);
				end else begin
					want = verdict_q.pop_front();
					verdicts++;
					if (seen.schedulable !== want.schedulable ||
						seen.utilization_sum !== want.utilization_sum ||
						seen.runnable_count !== want.runnable_count ||
						seen.period_error !== want.period_error) begin
						fail_count++;
						$display("%0t: verdict mismatch expected sched=%0d sum=%h cnt=%0d err=%0d",
							$time, want.schedulable, want.utilization_sum, want.runnable_count,
							want.period_error);
						$display("%0t:                  actual sched=%0d sum=%h cnt=%0d err=%0d",
							$time, seen.schedulable, seen.utilization_sum, seen.runnable_count,
							seen.period_error);
					end
				end
			end
			if (req.valid === 1'b1 && req.ready === 1'b1) begin
				if (req.is_runnable) begin
					if (runnable_tally < MAX_TASKS)
						runnable_tally++;
					if (req.task_period == '0) begin
						zero_period_flag = 1'b1;
					end else begin
						sum = 64'(util_acc) + task_share(req.task_compute, req.task_period);
						util_acc = (sum > 64'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];
					end
				end
				if (req.is_last) begin
					want.schedulable = !zero_period_flag &&
						(64'(util_acc) <= bound_for_count(runnable_tally));
					want.utilization_sum = util_acc;
					want.runnable_count = runnable_tally;
					want.period_error = zero_period_flag;
					verdict_q.push_back(want);
					util_acc = '0;
					runnable_tally = '0;
					zero_period_flag = 1'b0;
				end
			end
			pending = verdict_q.size();
		end
	end

endmodule

// File: tb/rm_utilization_bound_test_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rm_utilization_bound_test_tb
// Drives task record sets into the rate-monotonic admission test: a directed
// set of edge cases (exact bound, clipped quotients, zero periods, empty
// sets), then random sets near and far from the bound, including long and
// overloaded ones, under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module rm_utilization_bound_test_tb;
	import rmub_pkg::*;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   fail_count;
	int   pending;
	int   verdicts;
	int   record_count;
	int   set_count;
	int   phase_records;

	rmub_req_if req_if();
	rmub_rsp_if rsp_if();

	rm_utilization_bound_test dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	rmub_admission_monitor u_admission_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_if),
		.rsp        (rsp_if),
		.fail_count (fail_count),
		.pending    (pending),
		.verdicts   (verdicts)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[rm_utilization_bound_test] ERROR");
		$finish;
	end

	always @(negedge clk) begin
		rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_record(input logic [31:0] c, input logic [31:0] p,
		input logic r, input logic l);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.task_compute <= c;
		req_if.task_period <= p;
		req_if.is_runnable <= r;
		req_if.is_last <= l;
		@(posedge clk);
		while (req_if.ready !== 1'b1)
			@(posedge clk);
		record_count++;
		phase_records++;
		if (l)
			set_count++;
		@(negedge clk);
	endtask

	task automatic wait_for_verdicts();
		req_if.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic send_random_set();
		int                len;
		bit                heavy;
		int                mode;
		logic [31:0]       c;
		logic [31:0]       p;
		logic              r;
		longint unsigned   util_pick;
		heavy = 1'b0;
		if ($urandom_range(99) < 5) begin
			len = $urandom_range(33, 40);
			heavy = 1'($urandom_range(1));
		end else begin
			len = $urandom_range(1, 8);
		end
		for (int i = 0; i < len; i++) begin
			mode = $urandom_range(9);
			r = (len > 32) ? ($urandom_range(99) < 95) : ($urandom_range(99) < 85);
			if (heavy) begin
				// clipped quotients that push the sum into saturation
				p = $urandom_range(1, 4);
				c = $urandom;
			end else if (mode < 2) begin
				c = $urandom;
				p = $urandom;
			end else if (mode < 7) begin
				// utilization spread around the bound
				p = $urandom >> $urandom_range(0, 31);
				if (p == '0)
					p = 32'd1;
				util_pick = 64'($urandom_range(0, 131072 / len));
				c = 32'((64'(p) * util_pick) >> 16);
			end else if (mode < 9) begin
				c = $urandom_range(0, 20);
				p = $urandom_range(0, 20);
			end else begin
				c = $urandom >> $urandom_range(0, 31);
				p = $urandom >> $urandom_range(0, 31);
			end
			send_record(c, p, r, i == len - 1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.task_compute = '0;
		req_if.task_period = '0;
		req_if.is_runnable = 1'b0;
		req_if.is_last = 1'b0;
		send_idle_pct = 10;
		recv_stall_pct = 30;
		record_count = 0;
		set_count = 0;
		phase_records = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_record(32'd0, 32'd1, 1'b1, 1'b1);
		send_record(32'd1000, 32'd1000, 1'b1, 1'b1);
		send_record(32'd1001, 32'd1000, 1'b1, 1'b1);
		send_record(32'hFFFF_FFFF, 32'd1, 1'b1, 1'b1);
		send_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
		send_record(32'd5, 32'd0, 1'b1, 1'b1);
		send_record(32'd5, 32'd0, 1'b0, 1'b0);
		send_record(32'd1, 32'd4, 1'b1, 1'b1);
		send_record(32'd7, 32'd3, 1'b0, 1'b1);
		// two tasks landing exactly on the bound, then one step above it
		send_record(32'd27145, 32'd65536, 1'b1, 1'b0);
		send_record(32'd27145, 32'd65536, 1'b1, 1'b1);
		send_record(32'd27145, 32'd65536, 1'b1, 1'b0);
		send_record(32'd27146, 32'd65536, 1'b1, 1'b1);
		send_record(32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0);
		send_record(32'd3, 32'hFFFF_FFFF, 1'b1, 1'b1);
		wait_for_verdicts();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 20;
					recv_stall_pct = 84;
				end
				1: begin
					send_idle_pct = 84;
					recv_stall_pct = 20;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			phase_records = 0;
			while (phase_records < 200)
				send_random_set();
			wait_for_verdicts();
		end

		repeat (40) @(negedge clk);
		$display("covered %0d task records in %0d sets, %0d verdicts compared",
			record_count, set_count, verdicts);
		$display("sets included exact-bound, clipped, saturated, zero-period and empty cases");
		if (fail_count == 0)
			$display("[rm_utilization_bound_test] OK");
		else
			$display("[rm_utilization_bound_test] ERROR");
		$finish;
	end

endmodule
